>>> hw/rtl/icrb_pkg.sv
// Package for the clamp-to-edge convolution block.
// Holds operation and register codes, the cell control struct and the fixed field widths.
// No dependencies.
package icrb_pkg;

  localparam int ROW_W   = 12;
  localparam int OUTC_W  = 10;
  localparam int OUTCH_W = 2;
  localparam int SUM_W   = 32;
  localparam int PROD_W  = 25;
  localparam int WT_W    = 16;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 3;
  localparam int FRAC_W  = 12;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [SUM_W-1:0] HALF_LSB = 32'd2048;
  localparam logic [SUM_W-1:0] BYTE_TOP = 32'd1044480;
  localparam logic [SUM_W-1:0] BYTE_MAX = 32'd255;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [IDX_W-1:0] REG_KERNEL_RADIUS = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUTPUT_MODE   = 3'd4;

  localparam logic MODE_RAW  = 1'b0;
  localparam logic MODE_BYTE = 1'b1;

  typedef struct packed {
    logic clr;
    logic hit;
  } cell_ctl_t;

endpackage

>>> hw/rtl/icrb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module icrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/icrb_cell.sv
// One accumulate cell of the reduction chain: sums the products of one kernel row
// and adds its total onto the partial sum coming from its left neighbor. Uses icrb_pkg.
module icrb_cell
  import icrb_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctl_t                ctl_i,
  input  logic signed [PROD_W-1:0] prod_i,
  input  logic signed [SUM_W-1:0]  sum_i,
  output logic signed [SUM_W-1:0]  sum_o
);

  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] sum_q;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.hit) begin
      acc_d = acc_q + SUM_W'(prod_i);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sum_q <= sum_i + acc_q;
  end

  assign sum_o = sum_q;

endmodule

>>> hw/rtl/image_convolution_replicate_border_core.sv
// Top level of the streaming clamp-to-edge 2-D convolution block.
// Depends on icrb_pkg, icrb_ram (line store, weight table) and icrb_cell (reduction chain).
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+---------------------------------
//  in      | in_valid_i / in_ready_o                   | operation, weight or sample byte
//  out     | out_valid_o / out_ready_i                 | result value and its position
//  cfg     | cfg_valid_i / cfg_ready_o                 | register index and data
//
// A weight load or a sample that closes no output is taken without leaving the idle state.
// Each result steps through its side*side taps (one line-store read per cycle), then
// drains through the read, the multiply and the pass down the cell chain into the
// output register; a run at a right or bottom edge repeats this.
// Input is held off (in_ready_o low) while a run is in progress; a stalled output
// word holds everything. Reset clears counters and control; memories need no clearing.
module image_convolution_replicate_border_core
  import icrb_pkg::*;
#(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_KERNEL   = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [5:0]               weight_index_i,
  input  logic signed [WT_W-1:0]   weight_value_i,
  input  logic [PIX_W-1:0]         sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SUM_W-1:0]  result_value_o,
  output logic [ROW_W-1:0]         out_row_o,
  output logic [OUTC_W-1:0]        out_column_o,
  output logic [OUTCH_W-1:0]       out_channel_o,
  output logic                     last_in_run_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SLOT_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int RMAX     = (MAX_KERNEL - 1) / 2;
  localparam int WT_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int WT_AW    = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
  localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
  localparam int LS_AW    = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
  localparam int DRAIN_LEN = MAX_KERNEL + 3;
  localparam int DR_W     = $clog2(DRAIN_LEN + 1);
  localparam int YS_W     = ROW_W + 2;
  localparam int XS_W     = COL_W + 2;
  localparam int W_RST    = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  typedef enum logic [1:0] {ST_IDLE, ST_TAPS, ST_DRAIN, ST_OUT} state_e;

  state_e state_q;

  // Effective (saturated) configuration.
  logic [COL_W-1:0] wm1_q;
  logic [ROW_W-1:0] hm1_q;
  logic [CH_W-1:0]  ccm1_q;
  logic [1:0]       rad_q;
  logic             mode_q;

  // Frame position of the next sample.
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [CH_W-1:0]   ch_q;
  logic [SLOT_W-1:0] slot_q;

  // Run bookkeeping.
  logic [ROW_W-1:0]  cy_q, y_cur_q, y_end_q;
  logic [COL_W-1:0]  x_cur_q, x_start_q, x_end_q;
  logic [CH_W-1:0]   ch_run_q;
  logic [SLOT_W-1:0] slot_cy_q;

  // Tap sequencer.
  logic [SLOT_W-1:0] ay_q, ax_q;
  logic [WT_AW-1:0]  widx_q;
  logic [DR_W-1:0]   drain_q;

  // Tap pipeline.
  logic              t1_vld_q, prod_vld_q;
  logic [SLOT_W-1:0] t1_row_q, prod_row_q;
  logic signed [PROD_W-1:0] prod_q;

  // Output register.
  logic signed [SUM_W-1:0] res_q;
  logic [ROW_W-1:0]  orow_q;
  logic [COL_W-1:0]  ocol_q;
  logic [CH_W-1:0]   och_q;
  logic              olast_q;

  function automatic logic [LS_AW-1:0] ls_addr(input logic [SLOT_W-1:0] slot,
                                               input logic [COL_W-1:0] col,
                                               input logic [CH_W-1:0] ch);
    logic [LS_AW-1:0] a;
    a = LS_AW'(LS_AW'(slot) * LS_AW'(MAX_WIDTH * MAX_CHANNELS)
             + LS_AW'(col) * LS_AW'(MAX_CHANNELS) + LS_AW'(ch));
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_acc, smp_acc, wt_acc, cfg_we;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc  = in_valid_i && in_ready_o;
  assign smp_acc = in_acc && (operation_i == OP_SAMPLE);
  assign wt_acc  = in_acc && (operation_i == OP_WEIGHT)
                   && (32'(weight_index_i) < WT_DEPTH);
  assign cfg_we  = cfg_valid_i && cfg_ready_o;

  // ---------------------------------------------------------------------------
  // Configuration saturation
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] cfg_wm1;
  logic [ROW_W-1:0] cfg_hm1;
  logic [CH_W-1:0]  cfg_ccm1;
  logic [1:0]       cfg_rad;
  logic             cfg_hit;

  always_comb begin
    if (cfg_data_i[10:0] == 11'd0) begin
      cfg_wm1 = '0;
    end else if (32'(cfg_data_i[10:0]) > MAX_WIDTH) begin
      cfg_wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      cfg_wm1 = COL_W'(cfg_data_i[10:0] - 11'd1);
    end
    if (cfg_data_i == '0) begin
      cfg_hm1 = '0;
    end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
      cfg_hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      cfg_hm1 = ROW_W'(cfg_data_i - 13'd1);
    end
    if (cfg_data_i[2:0] == 3'd0) begin
      cfg_ccm1 = '0;
    end else if (32'(cfg_data_i[2:0]) > MAX_CHANNELS) begin
      cfg_ccm1 = CH_W'(MAX_CHANNELS - 1);
    end else begin
      cfg_ccm1 = CH_W'(cfg_data_i[2:0] - 3'd1);
    end
    if (32'(cfg_data_i[1:0]) > RMAX) begin
      cfg_rad = 2'(RMAX);
    end else begin
      cfg_rad = cfg_data_i[1:0];
    end
    cfg_hit = (cfg_index_i == REG_FRAME_WIDTH) || (cfg_index_i == REG_FRAME_HEIGHT)
           || (cfg_index_i == REG_CHANNEL_COUNT) || (cfg_index_i == REG_KERNEL_RADIUS)
           || (cfg_index_i == REG_OUTPUT_MODE);
  end

  // ---------------------------------------------------------------------------
  // Run bounds of the sample being accepted
  // ---------------------------------------------------------------------------
  logic y_last, x_last, has_run;
  logic signed [YS_W-1:0] ylo_s;
  logic signed [XS_W-1:0] xlo_s;
  logic [ROW_W-1:0] ylo, yhi;
  logic [COL_W-1:0] xlo, xhi;

  always_comb begin
    y_last = (row_q == hm1_q);
    x_last = (col_q == wm1_q);
    ylo_s  = $signed({2'b00, row_q}) - $signed(YS_W'(rad_q));
    xlo_s  = $signed({2'b00, col_q}) - $signed(XS_W'(rad_q));
    has_run = (y_last || !ylo_s[YS_W-1]) && (x_last || !xlo_s[XS_W-1]);
    ylo = (ylo_s[YS_W-1]) ? '0 : ylo_s[ROW_W-1:0];
    xlo = (xlo_s[XS_W-1]) ? '0 : xlo_s[COL_W-1:0];
    yhi = y_last ? row_q : ylo;
    xhi = x_last ? col_q : xlo;
  end

  // ---------------------------------------------------------------------------
  // Tap address generation: clamp into the frame, map the row to its store slot
  // ---------------------------------------------------------------------------
  logic signed [YS_W-1:0] sy_s;
  logic signed [XS_W-1:0] sx_s;
  logic [ROW_W-1:0]  sy, dy;
  logic [COL_W-1:0]  sx;
  logic [SLOT_W:0]   slot_diff;
  logic [SLOT_W-1:0] slot_rd;
  logic [SLOT_W-1:0] side_m1;
  logic tap_last;

  always_comb begin
    sy_s = $signed({2'b00, y_cur_q}) + $signed(YS_W'(ay_q)) - $signed(YS_W'(rad_q));
    sx_s = $signed({2'b00, x_cur_q}) + $signed(XS_W'(ax_q)) - $signed(XS_W'(rad_q));
    if (sy_s[YS_W-1]) begin
      sy = '0;
    end else if (sy_s[ROW_W-1:0] > hm1_q || sy_s[YS_W-2:ROW_W] != '0) begin
      sy = hm1_q;
    end else begin
      sy = sy_s[ROW_W-1:0];
    end
    if (sx_s[XS_W-1]) begin
      sx = '0;
    end else if (sx_s[COL_W-1:0] > wm1_q || sx_s[XS_W-2:COL_W] != '0) begin
      sx = wm1_q;
    end else begin
      sx = sx_s[COL_W-1:0];
    end
    dy = cy_q - sy;
    slot_diff = {1'b0, slot_cy_q} - {1'b0, dy[SLOT_W-1:0]};
    if (slot_diff[SLOT_W]) begin
      slot_rd = SLOT_W'(slot_diff + (SLOT_W+1)'(MAX_KERNEL));
    end else begin
      slot_rd = slot_diff[SLOT_W-1:0];
    end
    side_m1  = SLOT_W'({rad_q, 1'b0});
    tap_last = (ax_q == side_m1) && (ay_q == side_m1);
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] ls_rdata;
  logic [WT_W-1:0]  wt_rdata;

  icrb_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
    .clk_i  (clk_i),
    .we_i   (smp_acc),
    .waddr_i(ls_addr(slot_q, col_q, ch_q)),
    .wdata_i(sample_i),
    .raddr_i(ls_addr(slot_rd, sx, ch_run_q)),
    .rdata_o(ls_rdata)
  );

  icrb_ram #(.WIDTH(WT_W), .DEPTH(WT_DEPTH)) u_weight_table (
    .clk_i  (clk_i),
    .we_i   (wt_acc),
    .waddr_i(WT_AW'(weight_index_i)),
    .wdata_i(weight_value_i),
    .raddr_i(widx_q),
    .rdata_o(wt_rdata)
  );

  // ---------------------------------------------------------------------------
  // Cell chain: cell k sums kernel row k, partial sums ripple left to right
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] chain_sum [MAX_KERNEL+1];
  cell_ctl_t cell_ctl [MAX_KERNEL];
  logic go_taps;

  assign chain_sum[0] = '0;

  for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_cell
    assign cell_ctl[k].clr = go_taps;
    assign cell_ctl[k].hit = prod_vld_q && (prod_row_q == SLOT_W'(k));
    icrb_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (cell_ctl[k]),
      .prod_i(prod_q),
      .sum_i (chain_sum[k]),
      .sum_o (chain_sum[k+1])
    );
  end

  // Final conversion of the settled chain total.
  logic signed [SUM_W-1:0] total, res_d;
  logic [SUM_W-1:0] rounded;

  always_comb begin
    total   = chain_sum[MAX_KERNEL];
    rounded = (SUM_W'(total) + HALF_LSB) >> FRAC_W;
    if (mode_q == MODE_RAW) begin
      res_d = total;
    end else if (total < 0) begin
      res_d = '0;
    end else if (SUM_W'(total) > BYTE_TOP) begin
      res_d = BYTE_MAX;
    end else begin
      res_d = rounded;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic capture, out_acc, run_done;

  assign capture  = (state_q == ST_DRAIN) && (drain_q == DR_W'(DRAIN_LEN - 1));
  assign out_acc  = out_valid_o && out_ready_i;
  assign run_done = (x_cur_q == x_end_q) && (y_cur_q == y_end_q);
  assign go_taps  = (smp_acc && has_run) || (out_acc && !run_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wm1_q      <= COL_W'(W_RST - 1);
      hm1_q      <= ROW_W'(1023);
      ccm1_q     <= '0;
      rad_q      <= (RMAX < 1) ? 2'd0 : 2'd1;
      mode_q     <= MODE_BYTE;
      row_q      <= '0;
      col_q      <= '0;
      ch_q       <= '0;
      slot_q     <= '0;
      ay_q       <= '0;
      ax_q       <= '0;
      widx_q     <= '0;
      drain_q    <= '0;
      t1_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      // tap pipeline: memory read, then multiply
      t1_vld_q   <= (state_q == ST_TAPS);
      prod_vld_q <= t1_vld_q;

      case (state_q)
        ST_IDLE: begin
          if (smp_acc) begin
            // advance frame position
            if (ch_q == ccm1_q) begin
              ch_q <= '0;
              if (col_q == wm1_q) begin
                col_q <= '0;
                if (row_q == hm1_q) begin
                  row_q  <= '0;
                  slot_q <= '0;
                end else begin
                  row_q  <= row_q + 1'b1;
                  slot_q <= (slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_q + 1'b1;
                end
              end else begin
                col_q <= col_q + 1'b1;
              end
            end else begin
              ch_q <= ch_q + 1'b1;
            end
            if (has_run) begin
              state_q <= ST_TAPS;
            end
          end
        end
        ST_TAPS: begin
          widx_q <= widx_q + 1'b1;
          if (ax_q == side_m1) begin
            ax_q <= '0;
            ay_q <= ay_q + 1'b1;
          end else begin
            ax_q <= ax_q + 1'b1;
          end
          if (tap_last) begin
            state_q <= ST_DRAIN;
            drain_q <= '0;
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (capture) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            state_q <= run_done ? ST_IDLE : ST_TAPS;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (go_taps) begin
        ay_q   <= '0;
        ax_q   <= '0;
        widx_q <= '0;
      end

      // any listed register write restarts the frame
      if (cfg_we && cfg_hit) begin
        row_q  <= '0;
        col_q  <= '0;
        ch_q   <= '0;
        slot_q <= '0;
        case (cfg_index_i)
          REG_FRAME_WIDTH:   wm1_q  <= cfg_wm1;
          REG_FRAME_HEIGHT:  hm1_q  <= cfg_hm1;
          REG_CHANNEL_COUNT: ccm1_q <= cfg_ccm1;
          REG_KERNEL_RADIUS: rad_q  <= cfg_rad;
          REG_OUTPUT_MODE:   mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: run bounds, tap pipeline data, output word.
  always_ff @(posedge clk_i) begin
    t1_row_q   <= ay_q;
    prod_row_q <= t1_row_q;
    prod_q     <= $signed(wt_rdata) * $signed({1'b0, ls_rdata});
    if (smp_acc) begin
      cy_q      <= row_q;
      slot_cy_q <= slot_q;
      ch_run_q  <= ch_q;
      y_cur_q   <= ylo;
      y_end_q   <= yhi;
      x_cur_q   <= xlo;
      x_start_q <= xlo;
      x_end_q   <= xhi;
    end else if (out_acc && !run_done) begin
      if (x_cur_q == x_end_q) begin
        x_cur_q <= x_start_q;
        y_cur_q <= y_cur_q + 1'b1;
      end else begin
        x_cur_q <= x_cur_q + 1'b1;
      end
    end
    if (capture) begin
      res_q   <= res_d;
      orow_q  <= y_cur_q;
      ocol_q  <= x_cur_q;
      och_q   <= ch_run_q;
      olast_q <= run_done;
    end
  end

  assign result_value_o = res_q;
  assign out_row_o      = orow_q;
  assign out_column_o   = OUTC_W'(ocol_q);
  assign out_channel_o  = OUTCH_W'(och_q);
  assign last_in_run_o  = olast_q;

`ifndef SYNTHESIS
  a_in_out_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result word is pending");

  a_pipe_empty_at_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!t1_vld_q && !prod_vld_q))
    else $error("tap products still in flight when result is shown");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_hit) |=> (row_q == '0 && col_q == '0 && ch_q == '0))
    else $error("register write did not restart the frame");
`endif

endmodule
